@@ rtl/mse_pkg.sv @@
// Shared constants and types for the merge sort engine.
// No dependencies; used by every other file of the block but mse_ram.
package mse_pkg;

   // Element width and default batch capacity
   localparam int DATA_W   = 32;
   localparam int MSE_SIZE = 64;

   // Control from the sequencer to the result stage, one per memory read
   typedef struct packed {
      logic issue;   // a read of the next sorted element goes out this cycle
      logic last;    // that element closes the batch
      logic ovf;     // the batch lost elements at the full store
   } out_ctl_type;

endpackage

@@ rtl/mse_req_if.sv @@
// Input channel of the merge sort engine: one batch element per transaction.
// Depends on mse_pkg for the element width.
interface mse_req_if;
   logic                               valid;
   logic                               ready;
   logic signed [mse_pkg::DATA_W-1:0]  value;
   logic                               is_last;

   modport source (output valid, output value, output is_last, input ready);
   modport sink   (input valid, input value, input is_last, output ready);
endinterface

@@ rtl/mse_rsp_if.sv @@
// Result channel of the merge sort engine: one sorted element per transaction.
// Depends on mse_pkg for the element width.
interface mse_rsp_if;
   logic                               valid;
   logic                               ready;
   logic signed [mse_pkg::DATA_W-1:0]  sorted_value;
   logic                               end_of_batch;
   logic                               overflowed;

   modport source (output valid, output sorted_value, output end_of_batch,
                   output overflowed, input ready);
   modport sink   (input valid, input sorted_value, input end_of_batch,
                   input overflowed, output ready);
endinterface

@@ rtl/merge_sort_engine_unit.sv @@
// Merge sort engine: collects a batch of up to SIZE signed 32-bit values, one
// per input transaction; extra values are dropped and flag every result of
// that batch. The transaction marked is_last starts a bottom-up merge sort that
// ping-pongs between two RAMs: each pass writes one merged element per cycle,
// after a turnaround state for the RAM read latency, and ceil(log2 n) passes
// are run. The sorted values then leave in ascending order, each read from RAM
// and then held in the output register; a new read goes out only once the
// previous data has landed and the output register can take it, and the last
// one is marked end_of_batch. No input is taken while a batch is being sorted
// or read out; the final result may still wait at the output while the next
// batch loads.
// Depends on mse_pkg, mse_req_if, mse_rsp_if, mse_ram and mse_out_stage.
module merge_sort_engine_unit #(
   parameter int SIZE = mse_pkg::MSE_SIZE
) (
   input  logic      clock,
   input  logic      reset,
   mse_req_if.sink   req_ch,
   mse_rsp_if.source rsp_ch
);
   import mse_pkg::*;

   localparam int AW    = (SIZE > 1) ? $clog2(SIZE) : 1;
   localparam int CNT_W = $clog2(SIZE + 1);

   typedef enum logic [3:0] {
      ST_LOAD  = 4'b0001,
      ST_TURN  = 4'b0010,
      ST_MERGE = 4'b0100,
      ST_OUT   = 4'b1000
   } state_type;

   state_type        state_ff, state_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             drop_ff, drop_in;
   logic             sel_ff, sel_in;      // 0: RAM 0 holds the current run data
   logic [CNT_W-1:0] w_ff, w_in;          // run width of the current pass
   logic [CNT_W-1:0] a_ff, a_in, a_end_ff, a_end_in;
   logic [CNT_W-1:0] b_ff, b_in, b_end_ff, b_end_in;
   logic [CNT_W-1:0] k_ff, k_in;          // merge write index or read-out index

   logic                     accept;
   logic                     has_room;
   logic [CNT_W-1:0]         load_n;
   logic [CNT_W-1:0]         k_inc;
   logic [CNT_W:0]           w2;

   // Run-pair setup chain
   logic [CNT_W-1:0]         pair_lo, pair_w, pair_n, pair_ae, pair_be;
   logic [CNT_W:0]           sum_ae, sum_be;

   // Merge datapath
   logic signed [DATA_W-1:0] q0a, q0b, q1a, q1b, da, db, wdata;
   logic                     a_done, b_done, take_a;
   logic [CNT_W-1:0]         a_next, b_next;

   // RAM ports
   logic                     wr0_en, wr1_en;
   logic [AW-1:0]            wr0_addr, rd_addr_a, rd_addr_b;
   logic [DATA_W-1:0]        wr0_data;

   out_ctl_type              out_ctl;
   logic                     can_issue;

   assign req_ch.ready = (state_ff == ST_LOAD);
   assign accept       = req_ch.valid && req_ch.ready;
   assign has_room     = (count_ff < CNT_W'(SIZE));
   assign load_n       = has_room ? count_ff + CNT_W'(1) : count_ff;
   assign k_inc        = k_ff + CNT_W'(1);
   assign w2           = {w_ff, 1'b0};

   // Pick the source of the next run pair: start of a batch, new pass, next pair
   always_comb begin
      pair_lo = b_end_ff;
      pair_w  = w_ff;
      pair_n  = count_ff;
      case (state_ff)
         ST_LOAD: begin
            pair_lo = '0;
            pair_w  = CNT_W'(1);
            pair_n  = load_n;
         end
         ST_MERGE: begin
            if (k_inc == count_ff) begin
               pair_lo = '0;
               pair_w  = w2[CNT_W-1:0];
            end
         end
         default: begin
            pair_lo = b_end_ff;
         end
      endcase
   end

   // Clip both run ends at the batch size
   assign sum_ae  = {1'b0, pair_lo} + {1'b0, pair_w};
   assign pair_ae = (sum_ae > {1'b0, pair_n}) ? pair_n : sum_ae[CNT_W-1:0];
   assign sum_be  = {1'b0, pair_ae} + {1'b0, pair_w};
   assign pair_be = (sum_be > {1'b0, pair_n}) ? pair_n : sum_be[CNT_W-1:0];

   // Select the source RAM and merge one element
   assign da     = sel_ff ? q1a : q0a;
   assign db     = sel_ff ? q1b : q0b;
   assign a_done = (a_ff == a_end_ff);
   assign b_done = (b_ff == b_end_ff);
   assign take_a = !a_done && (b_done || (da <= db));
   assign wdata  = take_a ? da : db;
   assign a_next = a_ff + CNT_W'(take_a);
   assign b_next = b_ff + CNT_W'(!take_a);

   // Sequencer
   always_comb begin
      state_in  = state_ff;
      count_in  = count_ff;
      drop_in   = drop_ff;
      sel_in    = sel_ff;
      w_in      = w_ff;
      a_in      = a_ff;
      a_end_in  = a_end_ff;
      b_in      = b_ff;
      b_end_in  = b_end_ff;
      k_in      = k_ff;
      out_ctl   = '0;
      case (state_ff)
         ST_LOAD: begin
            if (accept) begin
               count_in = load_n;
               if (!has_room) begin
                  drop_in = 1'b1;
               end
               if (req_ch.is_last) begin
                  sel_in = 1'b0;
                  k_in   = '0;
                  if (load_n > CNT_W'(1)) begin
                     w_in     = CNT_W'(1);
                     a_in     = '0;
                     a_end_in = pair_ae;
                     b_in     = pair_ae;
                     b_end_in = pair_be;
                     state_in = ST_TURN;
                  end else begin
                     state_in = ST_OUT;
                  end
               end
            end
         end
         ST_TURN: begin
            // Reads of the new source go out this cycle, after its last write
            state_in = ST_MERGE;
         end
         ST_MERGE: begin
            k_in = k_inc;
            if (k_inc == count_ff) begin
               sel_in = !sel_ff;
               k_in   = '0;
               if (w2 < {1'b0, count_ff}) begin
                  w_in     = w2[CNT_W-1:0];
                  a_in     = '0;
                  a_end_in = pair_ae;
                  b_in     = pair_ae;
                  b_end_in = pair_be;
                  state_in = ST_TURN;
               end else begin
                  state_in = ST_OUT;
               end
            end else if (k_inc == b_end_ff) begin
               a_in     = pair_lo;
               a_end_in = pair_ae;
               b_in     = pair_ae;
               b_end_in = pair_be;
            end else begin
               a_in = a_next;
               b_in = b_next;
            end
         end
         ST_OUT: begin
            out_ctl.issue = can_issue;
            out_ctl.last  = (k_inc == count_ff);
            out_ctl.ovf   = drop_ff;
            if (can_issue) begin
               k_in = k_inc;
               if (k_inc == count_ff) begin
                  count_in = '0;
                  drop_in  = 1'b0;
                  state_in = ST_LOAD;
               end
            end
         end
         default: begin
            state_in = ST_LOAD;
         end
      endcase
   end

   // Registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_LOAD;
         count_ff <= '0;
         drop_ff  <= 1'b0;
         sel_ff   <= 1'b0;
         w_ff     <= '0;
         a_ff     <= '0;
         a_end_ff <= '0;
         b_ff     <= '0;
         b_end_ff <= '0;
         k_ff     <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         drop_ff  <= drop_in;
         sel_ff   <= sel_in;
         w_ff     <= w_in;
         a_ff     <= a_in;
         a_end_ff <= a_end_in;
         b_ff     <= b_in;
         b_end_ff <= b_end_in;
         k_ff     <= k_in;
      end
   end

   // RAM 0 takes the loaded batch and the even passes; RAM 1 the odd ones
   assign wr0_en    = (accept && has_room) || ((state_ff == ST_MERGE) && sel_ff);
   assign wr0_addr  = (state_ff == ST_LOAD) ? count_ff[AW-1:0] : k_ff[AW-1:0];
   assign wr0_data  = (state_ff == ST_LOAD) ? req_ch.value : wdata;
   assign wr1_en    = (state_ff == ST_MERGE) && !sel_ff;
   assign rd_addr_a = (state_ff == ST_OUT) ? k_ff[AW-1:0] : a_in[AW-1:0];
   assign rd_addr_b = b_in[AW-1:0];

   mse_ram #(
      .WIDTH (DATA_W),
      .DEPTH (SIZE)
   ) u_ram0 (
      .clock     (clock),
      .wr_en     (wr0_en),
      .wr_addr   (wr0_addr),
      .wr_data   (wr0_data),
      .rd_addr_a (rd_addr_a),
      .rd_addr_b (rd_addr_b),
      .rd_data_a (q0a),
      .rd_data_b (q0b)
   );

   mse_ram #(
      .WIDTH (DATA_W),
      .DEPTH (SIZE)
   ) u_ram1 (
      .clock     (clock),
      .wr_en     (wr1_en),
      .wr_addr   (k_ff[AW-1:0]),
      .wr_data   (wdata),
      .rd_addr_a (rd_addr_a),
      .rd_addr_b (rd_addr_b),
      .rd_data_a (q1a),
      .rd_data_b (q1b)
   );

   mse_out_stage u_out (
      .clock     (clock),
      .reset     (reset),
      .ctl       (out_ctl),
      .rd_data   (da),
      .can_issue (can_issue),
      .rsp_ch    (rsp_ch)
   );

`ifndef SYNTHESIS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(SIZE))
      else $error("element count beyond capacity");

   a_merge_index: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_MERGE) |-> (k_ff < count_ff))
      else $error("merge write index past the batch");

   a_run_order: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_MERGE) |->
         ((a_ff <= a_end_ff) && (a_end_ff <= b_ff) && (b_ff <= b_end_ff)
          && (b_end_ff <= count_ff)))
      else $error("run pointers out of order");
`endif

endmodule

@@ rtl/mse_ram.sv @@
// Generic synchronous RAM: one write port, two read ports, registered read data.
// No dependencies.
module mse_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                      clock,
   input  logic                      wr_en,
   input  logic [$clog2(DEPTH)-1:0]  wr_addr,
   input  logic [WIDTH-1:0]          wr_data,
   input  logic [$clog2(DEPTH)-1:0]  rd_addr_a,
   input  logic [$clog2(DEPTH)-1:0]  rd_addr_b,
   output logic [WIDTH-1:0]          rd_data_a,
   output logic [WIDTH-1:0]          rd_data_b
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_a_ff;
   logic [WIDTH-1:0] rd_data_b_ff;

   // Write, and register both read ports (old data on a same-cycle write)
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_a_ff <= mem_ff[rd_addr_a];
      rd_data_b_ff <= mem_ff[rd_addr_b];
   end

   assign rd_data_a = rd_data_a_ff;
   assign rd_data_b = rd_data_b_ff;

endmodule

@@ rtl/mse_out_stage.sv @@
// Result stage: catches the memory read data in the cycle after the read and
// holds it in the output register until the result transaction completes.
// Depends on mse_pkg and mse_rsp_if.
module mse_out_stage (
   input  logic                              clock,
   input  logic                              reset,
   input  mse_pkg::out_ctl_type              ctl,
   input  logic signed [mse_pkg::DATA_W-1:0] rd_data,
   output logic                              can_issue,
   mse_rsp_if.source                         rsp_ch
);
   import mse_pkg::*;

   logic                      pend_ff, pend_in;
   logic                      pend_last_ff;
   logic                      pend_ovf_ff;
   logic                      valid_ff, valid_in;
   logic signed [DATA_W-1:0]  value_ff;
   logic                      last_ff;
   logic                      ovf_ff;

   // A read may go out only if its data finds the output register empty
   assign can_issue = !pend_ff && (!valid_ff || rsp_ch.ready);

   always_comb begin
      pend_in  = ctl.issue;
      valid_in = valid_ff;
      if (pend_ff) begin
         valid_in = 1'b1;
      end else if (valid_ff && rsp_ch.ready) begin
         valid_in = 1'b0;
      end
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff  <= 1'b0;
         valid_ff <= 1'b0;
      end else begin
         pend_ff  <= pend_in;
         valid_ff <= valid_in;
      end
   end

   // Payload: flags travel alongside the read, data arrives in the next cycle
   always_ff @(posedge clock) begin
      if (ctl.issue) begin
         pend_last_ff <= ctl.last;
         pend_ovf_ff  <= ctl.ovf;
      end
      if (pend_ff) begin
         value_ff <= rd_data;
         last_ff  <= pend_last_ff;
         ovf_ff   <= pend_ovf_ff;
      end
   end

   assign rsp_ch.valid        = valid_ff;
   assign rsp_ch.sorted_value = value_ff;
   assign rsp_ch.end_of_batch = last_ff;
   assign rsp_ch.overflowed   = ovf_ff;

`ifndef SYNTHESIS
   // Read data must never land on a result that is still waiting
   a_pend_into_empty: assert property (@(posedge clock) disable iff (reset)
      pend_ff |-> !valid_ff)
      else $error("read data arrived while the output register was full");
`endif

endmodule
